FILE: design/rnsmau_pkg.sv
// rnsmau_pkg: shared types, command codes and the build-time moduli search
// for the residue arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package rnsmau_pkg;

    // command codes
    localparam logic [2:0] CMD_SET  = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_READ = 3'd5;

    localparam int MAX_MODULI = 64;

    typedef logic [31:0] t_mod_tab [MAX_MODULI];

    // control into the lane engine
    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } t_eng_ctl;

    // status out of the lane engine
    typedef struct packed {
        logic done;
        logic ok;
    } t_eng_sts;

    // gcd of two odd values by subtract and shift
    function automatic longint odd_gcd(longint a_in, longint b_in);
        longint a;
        longint b;
        a = a_in;
        b = b_in;
        while (a != b) begin
            if (a > b) begin
                a = a - b;
                while (a[0] == 1'b0) a = a >> 1;
            end else begin
                b = b - a;
                while (b[0] == 1'b0) b = b >> 1;
            end
        end
        return a;
    endfunction

    // step down from 2^width-1, keep odd values free of small factors
    // and coprime with every modulus kept so far; leftover lanes get 1
    function automatic t_mod_tab build_moduli(int count, int width);
        t_mod_tab tab;
        longint   c;
        int       kept;
        bit       ok;
        for (int i = 0; i < MAX_MODULI; i++) tab[i] = 32'd1;
        kept = 0;
        c = (longint'(1) << width) - 1;
        while (kept < count && c > 1) begin
            ok = (c[0] == 1'b1) && ((c % 3) != 0) && ((c % 5) != 0) && ((c % 7) != 0);
            for (int k = 0; k < kept; k++) begin
                if (ok && odd_gcd(c, longint'(tab[k])) != 1) ok = 1'b0;
            end
            if (ok) begin
                tab[kept] = c[31:0];
                kept++;
            end
            c = c - 1;
        end
        return tab;
    endfunction

endpackage

FILE: design/rnsmau_cmd_if.sv
// rnsmau_cmd_if: command channel (valid, ready, command fields)
// depends on nothing
`timescale 1ns / 1ps

interface rnsmau_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [2:0]  dest_reg;
    logic [2:0]  src_a_reg;
    logic [2:0]  src_b_reg;
    logic [31:0] value;

    modport source (output valid, command, dest_reg, src_a_reg, src_b_reg, value,
                    input ready);
    modport sink (input valid, command, dest_reg, src_a_reg, src_b_reg, value,
                  output ready);
endinterface

FILE: design/rnsmau_rsp_if.sv
// rnsmau_rsp_if: result channel (valid, ready, residue, lane, status, last)
// depends on nothing
`timescale 1ns / 1ps

interface rnsmau_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] residue;
    logic [4:0]  lane_index;
    logic        status;
    logic        last;

    modport source (output valid, residue, lane_index, status, last, input ready);
    modport sink (input valid, residue, lane_index, status, last, output ready);
endinterface

FILE: design/rns_modular_arithmetic_unit.sv
// rns_modular_arithmetic_unit: residue register file, lane sequencer and
// result channel. Uses rnsmau_pkg, rnsmau_cmd_if, rnsmau_rsp_if, rnsmau_lane_engine.
//
//   channel  dir  payload                                         notes
//   i_cmd    in   command, dest_reg, src_a_reg, src_b_reg, value  one command
//   o_rsp    out  residue, lane_index, status, last               1 or NUM_MODULI
//
// One command at a time; ready is low while a command is in progress.
// Per lane through the shared engine: add and sub, bit-serial mul, set by reducing
// the value, and divide by reducing the value, then the inverse steps, then a
// multiply when an inverse exists. Read steps the lanes through the registered read.
// After reset a clearing pass writes zero to NUM_REGS*NUM_MODULI entries, one
// per cycle, before the first command is taken. Result stalls hold the sequencer.
`timescale 1ns / 1ps

module rns_modular_arithmetic_unit #(
    parameter int NUM_MODULI = 32,
    parameter int NUM_REGS   = 8,
    parameter int MOD_WIDTH  = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rnsmau_cmd_if.sink   i_cmd,
    rnsmau_rsp_if.source o_rsp
);

    localparam int W     = MOD_WIDTH;
    localparam int LW    = $clog2(NUM_MODULI);
    localparam int RW    = $clog2(NUM_REGS);
    localparam int DEPTH = NUM_REGS * NUM_MODULI;
    localparam int AW    = $clog2(DEPTH);
    localparam rnsmau_pkg::t_mod_tab MODULI =
        rnsmau_pkg::build_moduli(NUM_MODULI, MOD_WIDTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_GO    = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_RSP   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // register index folded into the file depth
    function automatic logic [RW-1:0] reg_fold(logic [2:0] idx);
        int r;
        r = int'(idx);
        for (int k = 0; k < 8; k++) begin
            if (r >= NUM_REGS) r = r - NUM_REGS;
        end
        return RW'(r);
    endfunction

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    logic [RW-1:0] r_d, n_d;
    logic [RW-1:0] r_a, n_a;
    logic [RW-1:0] r_b, n_b;
    logic [31:0]   r_v, n_v;
    logic [LW-1:0] r_lane, n_lane;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_status, n_status;
    logic [W-1:0]  r_x, n_x;

    logic [W-1:0]  r_mem [DEPTH];
    logic [W-1:0]  r_rdata;
    logic [RW-1:0] w_rreg;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    logic [W-1:0]  w_wdata;

    rnsmau_pkg::t_eng_ctl w_ctl;
    rnsmau_pkg::t_eng_sts w_sts;
    logic [W-1:0]         w_res;
    logic [W-1:0]         w_mod;
    logic                 w_last_lane;

    assign w_mod       = W'(MODULI[r_lane]);
    assign w_last_lane = (r_lane == LW'(NUM_MODULI - 1));

    // residue file addressing
    always_comb begin
        if (r_state == S_RDA && r_cmd != rnsmau_pkg::CMD_DIV) begin
            w_rreg = r_a;
        end else if (r_state == S_RDB) begin
            w_rreg = r_b;
        end else begin
            w_rreg = r_d;
        end
        w_raddr = AW'(w_rreg) * AW'(NUM_MODULI) + AW'(r_lane);
        w_waddr = (r_state == S_CLEAR) ? r_clr : AW'(r_d) * AW'(NUM_MODULI) + AW'(r_lane);
        w_we    = (r_state == S_CLEAR) || (r_state == S_WAIT && w_sts.done && w_sts.ok);
        w_wdata = (r_state == S_CLEAR) ? '0 : w_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // shared lane engine
    assign w_ctl.start = (r_state == S_GO);
    assign w_ctl.op    = r_cmd;

    rnsmau_lane_engine #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (r_x),
        .i_y     (r_rdata),
        .i_m     (w_mod),
        .i_v     (r_v),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    // command sequencer
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_d      = r_d;
        n_a      = r_a;
        n_b      = r_b;
        n_v      = r_v;
        n_lane   = r_lane;
        n_clr    = r_clr;
        n_status = r_status;
        n_x      = r_x;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.command;
                    n_d      = reg_fold(i_cmd.dest_reg);
                    n_a      = reg_fold(i_cmd.src_a_reg);
                    n_b      = reg_fold(i_cmd.src_b_reg);
                    n_v      = i_cmd.value;
                    n_lane   = '0;
                    n_status = 1'b0;
                    case (i_cmd.command)
                        rnsmau_pkg::CMD_SET, rnsmau_pkg::CMD_ADD, rnsmau_pkg::CMD_SUB,
                        rnsmau_pkg::CMD_MUL, rnsmau_pkg::CMD_DIV: n_state = S_RDA;
                        rnsmau_pkg::CMD_READ: n_state = S_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: begin
                n_x     = r_rdata;
                n_state = S_GO;
            end
            S_GO: n_state = S_WAIT;
            S_WAIT: begin
                if (w_sts.done) begin
                    if (!w_sts.ok) n_status = 1'b1;
                    if (w_last_lane) begin
                        n_state = S_RSP;
                    end else begin
                        n_lane  = r_lane + LW'(1);
                        n_state = S_RDA;
                    end
                end
            end
            S_RSP: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            S_OUT: begin
                // data is valid once the registered read has settled (r_status set); the address holds on stall
                if (o_rsp.ready && r_status) begin
                    if (w_last_lane) begin
                        n_state = S_IDLE;
                    end else begin
                        n_lane   = r_lane + LW'(1);
                        n_status = 1'b0;
                    end
                end else begin
                    n_status = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_lane   <= '0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_lane   <= n_lane;
            r_status <= n_status;
        end
        r_cmd <= n_cmd;
        r_d   <= n_d;
        r_a   <= n_a;
        r_b   <= n_b;
        r_v   <= n_v;
        r_x   <= n_x;
    end

    // result channel; during read r_status marks the read data as settled
    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_RSP) || (r_state == S_OUT && r_status);
    assign o_rsp.residue    = (r_state == S_OUT) ? 31'(r_rdata) : '0;
    assign o_rsp.lane_index = (r_state == S_OUT) ? 5'(r_lane) : '0;
    assign o_rsp.status     = (r_state == S_RSP) ? r_status : 1'b0;
    assign o_rsp.last       = (r_state == S_RSP) || (r_state == S_OUT && w_last_lane);

endmodule

FILE: design/rnsmau_lane_engine.sv
// rnsmau_lane_engine: iterative modular unit for one lane: add, sub,
// bit-serial multiply-reduce and binary extended gcd inverse. Uses rnsmau_pkg.
`timescale 1ns / 1ps

module rnsmau_lane_engine #(
    parameter int MOD_WIDTH = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rnsmau_pkg::t_eng_ctl    i_ctl,
    input  logic [MOD_WIDTH-1:0]    i_x,
    input  logic [MOD_WIDTH-1:0]    i_y,
    input  logic [MOD_WIDTH-1:0]    i_m,
    input  logic [31:0]             i_v,
    output rnsmau_pkg::t_eng_sts    o_sts,
    output logic [MOD_WIDTH-1:0]    o_res
);

    localparam int W = MOD_WIDTH;
    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_MUL  = 2'd1;
    localparam logic [1:0] E_INV  = 2'd2;
    localparam logic [1:0] E_DONE = 2'd3;

    logic [1:0]   r_state, n_state;
    logic [2:0]   r_op, n_op;
    logic         r_stage, n_stage;
    logic         r_ok, n_ok;
    logic [5:0]   r_cnt, n_cnt;
    logic [31:0]  r_mplier, n_mplier;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_mcand, n_mcand;
    logic [W-1:0] r_old, n_old;
    logic [W-1:0] r_m, n_m;
    logic [W-1:0] r_u, n_u;
    logic [W-1:0] r_v, n_v;
    logic [W-1:0] r_x1, n_x1;
    logic [W-1:0] r_x2, n_x2;
    logic [W-1:0] r_res, n_res;

    logic [W:0]   w_dbl, w_dbl_red, w_sum, w_step;
    logic [W-1:0] w_one, w_m_one;
    logic [W:0]   w_add, w_x1_half_s, w_x2_half_s;
    logic [W-1:0] w_x1_sub, w_x2_sub;

    // modulus one maps every value to zero
    assign w_one   = (i_m == W'(1)) ? '0 : W'(1);
    assign w_m_one = (r_m == W'(1)) ? '0 : W'(1);

    // one step of double, add the multiplicand when the multiplier bit is set, reduce
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_m}) ? w_dbl - {1'b0, r_m} : w_dbl;
        w_sum     = w_dbl_red + (r_mplier[31] ? {1'b0, r_mcand} : '0);
        w_step    = (w_sum >= {1'b0, r_m}) ? w_sum - {1'b0, r_m} : w_sum;
    end

    // lane add for the add command
    assign w_add = {1'b0, i_x} + {1'b0, i_y};

    // inverse helpers: halving mod m and modular difference
    assign w_x1_half_s = r_x1[0] ? ({1'b0, r_x1} + {1'b0, r_m}) : {1'b0, r_x1};
    assign w_x2_half_s = r_x2[0] ? ({1'b0, r_x2} + {1'b0, r_m}) : {1'b0, r_x2};
    assign w_x1_sub = (r_x1 >= r_x2) ? r_x1 - r_x2 : r_x1 + (r_m - r_x2);
    assign w_x2_sub = (r_x2 >= r_x1) ? r_x2 - r_x1 : r_x2 + (r_m - r_x1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_stage  = r_stage;
        n_ok     = r_ok;
        n_cnt    = r_cnt;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_old    = r_old;
        n_m      = r_m;
        n_u      = r_u;
        n_v      = r_v;
        n_x1     = r_x1;
        n_x2     = r_x2;
        n_res    = r_res;
        unique case (r_state)
            E_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_ctl.op;
                    n_m     = i_m;
                    n_old   = i_x;
                    n_ok    = 1'b1;
                    n_stage = 1'b0;
                    n_acc   = '0;
                    case (i_ctl.op)
                        rnsmau_pkg::CMD_ADD: begin
                            n_res   = (w_add >= {1'b0, i_m}) ? W'(w_add - {1'b0, i_m})
                                                              : W'(w_add);
                            n_state = E_DONE;
                        end
                        rnsmau_pkg::CMD_SUB: begin
                            n_res   = (i_x >= i_y) ? i_x - i_y : i_x + (i_m - i_y);
                            n_state = E_DONE;
                        end
                        rnsmau_pkg::CMD_MUL: begin
                            n_mcand  = i_x;
                            n_mplier = 32'(i_y) << (32 - W);
                            n_cnt    = 6'(W);
                            n_state  = E_MUL;
                        end
                        default: begin
                            // set and divide both start by reducing the value
                            n_mcand  = w_one;
                            n_mplier = i_v;
                            n_cnt    = 6'd32;
                            n_state  = E_MUL;
                        end
                    endcase
                end
            end
            E_MUL: begin
                n_acc    = W'(w_step);
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    if (r_op == rnsmau_pkg::CMD_DIV && !r_stage) begin
                        n_u     = W'(w_step);
                        n_v     = r_m;
                        n_x1    = w_m_one;
                        n_x2    = '0;
                        n_state = E_INV;
                    end else begin
                        n_res   = W'(w_step);
                        n_state = E_DONE;
                    end
                end
            end
            E_INV: begin
                if (r_u == '0) begin
                    if (r_v == W'(1)) begin
                        n_acc    = '0;
                        n_mcand  = r_old;
                        n_mplier = 32'(r_x2) << (32 - W);
                        n_cnt    = 6'(W);
                        n_stage  = 1'b1;
                        n_state  = E_MUL;
                    end else begin
                        n_ok    = 1'b0;
                        n_res   = r_old;
                        n_state = E_DONE;
                    end
                end else if (!r_u[0]) begin
                    n_u  = r_u >> 1;
                    n_x1 = W'(w_x1_half_s >> 1);
                end else if (!r_v[0]) begin
                    n_v  = r_v >> 1;
                    n_x2 = W'(w_x2_half_s >> 1);
                end else if (r_u >= r_v) begin
                    n_u  = r_u - r_v;
                    n_x1 = w_x1_sub;
                end else begin
                    n_v  = r_v - r_u;
                    n_x2 = w_x2_sub;
                end
            end
            E_DONE: begin
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op     <= n_op;
        r_stage  <= n_stage;
        r_ok     <= n_ok;
        r_cnt    <= n_cnt;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_old    <= n_old;
        r_m      <= n_m;
        r_u      <= n_u;
        r_v      <= n_v;
        r_x1     <= n_x1;
        r_x2     <= n_x2;
        r_res    <= n_res;
    end

    assign o_sts.done = (r_state == E_DONE);
    assign o_sts.ok   = r_ok;
    assign o_res      = r_res;

endmodule
